/* sv/film_separation_force_check_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef FILM_SEPARATION_FORCE_CHECK_CORE_ASSERT_SVH
`define FILM_SEPARATION_FORCE_CHECK_CORE_ASSERT_SVH

// Check a property while the block is out of reset.
`define FSFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fsfc assertion failed");

// Check a property at every edge, reset included.
`define FSFC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fsfc assertion failed");

`endif

/* sv/fsfc_pkg.sv */
package fsfc_pkg;

    localparam int WORD_BITS = 48;
    localparam int FRAC_BITS = 24;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [WORD_BITS-1:0]        t_mag;

    localparam t_word WMAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WMIN     = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_mag  LIM_POS  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_mag  LIM_NEG  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word ONE_Q    = t_word'(64'd1 << FRAC_BITS);
    localparam t_word NEG_ONE_Q = -ONE_Q;
    localparam t_mag  EPS_Q    = t_mag'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam t_mag  K43_Q    = t_mag'(((64'd4 << FRAC_BITS) + 64'd1) / 64'd3);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAVITY   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RATIO = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CURV  = 3'd4;

    // Four half-width partial products and the product sign
    typedef struct packed {
        logic [WORD_BITS-1:0] ll;
        logic [WORD_BITS-1:0] lh;
        logic [WORD_BITS-1:0] hl;
        logic [WORD_BITS-1:0] hh;
        logic                 neg;
    } t_pp;

    // Payload handed to the divider pipeline
    typedef struct packed {
        t_word num;
        t_word den;
        t_word side;
        logic  eval;
    } t_div_req;

    typedef struct packed {
        t_word quo;
        t_word side;
        logic  eval;
    } t_div_rsp;

    function automatic t_mag mag_of(t_word v);
        return v[WORD_BITS-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    function automatic t_word sat_add(t_word a, t_word b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WMIN : WMAX;
        end
        return t_word'(s[WORD_BITS-1:0]);
    endfunction

    function automatic t_pp mul_pp(t_mag a, t_mag b, logic neg);
        t_pp p;
        p.ll  = a[HALF_BITS-1:0] * b[HALF_BITS-1:0];
        p.lh  = a[HALF_BITS-1:0] * b[WORD_BITS-1:HALF_BITS];
        p.hl  = a[WORD_BITS-1:HALF_BITS] * b[HALF_BITS-1:0];
        p.hh  = a[WORD_BITS-1:HALF_BITS] * b[WORD_BITS-1:HALF_BITS];
        p.neg = neg;
        return p;
    endfunction

    // Sum the partials, drop fraction bits, saturate, apply sign
    function automatic t_word mul_fin(t_pp p);
        logic [2*WORD_BITS-1:0] full;
        logic [2*WORD_BITS-1:0] sh;
        t_mag lim;
        t_mag m;
        full = {{WORD_BITS{1'b0}}, p.ll}
             + ({{WORD_BITS{1'b0}}, p.lh} << HALF_BITS)
             + ({{WORD_BITS{1'b0}}, p.hl} << HALF_BITS)
             + {p.hh, {WORD_BITS{1'b0}}};
        sh  = full >> FRAC_BITS;
        lim = p.neg ? LIM_NEG : LIM_POS;
        m   = (sh > {{WORD_BITS{1'b0}}, lim}) ? lim : sh[WORD_BITS-1:0];
        return p.neg ? t_word'(-m) : t_word'(m);
    endfunction

endpackage

/* sv/fsfc_div.sv */
module fsfc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  fsfc_pkg::t_div_req  i_req,
    output logic                o_valid,
    output fsfc_pkg::t_div_rsp  o_rsp
);

    localparam int W     = fsfc_pkg::WORD_BITS;
    localparam int F     = fsfc_pkg::FRAC_BITS;
    localparam int STEPS = fsfc_pkg::WORD_BITS;

    fsfc_pkg::t_mag   n_ma;
    fsfc_pkg::t_mag   n_d;
    logic             n_ovf;

    logic [W-1:0]     r_rem  [0:STEPS];
    logic [W-1:0]     r_low  [0:STEPS];
    logic [W-1:0]     r_quo  [0:STEPS];
    logic [W-1:0]     r_den  [0:STEPS];
    logic             r_neg  [0:STEPS];
    logic             r_zero [0:STEPS];
    logic             r_sat  [0:STEPS];
    fsfc_pkg::t_word  r_side [0:STEPS];
    logic             r_eval [0:STEPS];
    logic [STEPS+1:0] r_vld;

    logic [W:0]       n_r2   [1:STEPS];
    logic             n_ge   [1:STEPS];

    fsfc_pkg::t_mag   n_lim;
    fsfc_pkg::t_mag   n_m;
    fsfc_pkg::t_word  n_quo;

    always_comb begin
        n_ma  = fsfc_pkg::mag_of(i_req.num);
        n_d   = fsfc_pkg::mag_of(i_req.den);
        // quotient reaches 2^W: certain saturation
        n_ovf = {{F{1'b0}}, n_ma} >= {n_d, {F{1'b0}}};
    end

    always_comb begin
        for (int s = 1; s <= STEPS; s++) begin
            n_r2[s] = {r_rem[s-1], r_low[s-1][W-1]};
            n_ge[s] = n_r2[s] >= {1'b0, r_den[s-1]};
        end
    end

    always_comb begin
        n_lim = r_neg[STEPS] ? fsfc_pkg::LIM_NEG : fsfc_pkg::LIM_POS;
        n_m   = (r_quo[STEPS] > n_lim) ? n_lim : r_quo[STEPS];
        if (r_zero[STEPS]) begin
            n_quo = '0;
        end else if (r_sat[STEPS]) begin
            n_quo = r_neg[STEPS] ? fsfc_pkg::WMIN : fsfc_pkg::WMAX;
        end else begin
            n_quo = r_neg[STEPS] ? fsfc_pkg::t_word'(-n_m) : fsfc_pkg::t_word'(n_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {{(W-F){1'b0}}, n_ma[W-1:F]};
            r_low[0]  <= {n_ma[F-1:0], {(W-F){1'b0}}};
            r_quo[0]  <= '0;
            r_den[0]  <= n_d;
            r_neg[0]  <= i_req.num[W-1] ^ i_req.den[W-1];
            r_zero[0] <= (n_ma == '0);
            r_sat[0]  <= n_ovf;
            r_side[0] <= i_req.side;
            r_eval[0] <= i_req.eval;
            for (int s = 1; s <= STEPS; s++) begin
                r_rem[s]  <= n_ge[s] ? W'(n_r2[s] - {1'b0, r_den[s-1]}) : n_r2[s][W-1:0];
                r_low[s]  <= {r_low[s-1][W-2:0], 1'b0};
                r_quo[s]  <= {r_quo[s-1][W-2:0], n_ge[s]};
                r_den[s]  <= r_den[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_sat[s]  <= r_sat[s-1];
                r_side[s] <= r_side[s-1];
                r_eval[s] <= r_eval[s-1];
            end
            o_rsp.quo  <= n_quo;
            o_rsp.side <= r_side[STEPS];
            o_rsp.eval <= r_eval[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STEPS:0], i_valid};
        end
    end

    assign o_valid = r_vld[STEPS+1];

endmodule

/* sv/film_separation_force_check_core.sv */
// Film separation force check: one film face in, one verdict out.
// Input channel: i_in_valid with o_in_stall; a beat carries thickness,
// density, squared speed, raw curvature, raw gravity cosine and surface
// tension. Output channel: o_out_valid with i_out_stall; a beat carries the
// saturated net force and the evaluated and separated flags.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 gravity, 1 threshold, 2 defined radius, 3 min thickness ratio,
// 4 min curvature); unknown indexes are dropped.
// Throughput: one beat per cycle while o_in_stall is low. A beat passes
// the 2-stage split multipliers, the bit-per-stage divider that forms the
// surface term, and two output stages before its result beat.
// A write to the defined radius starts a serial reciprocal unit that works
// one quotient bit per cycle; o_in_stall stays high meanwhile.
// Reset (synchronous, active low) restores register defaults and empties
// the pipeline. When the receiver stalls a waiting result, every stage
// holds and o_in_stall rises the same cycle; nothing is dropped or repeated.
module film_separation_force_check_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [46:0]                            i_film_thickness,
    input  logic [46:0]                            i_density,
    input  logic [46:0]                            i_speed_squared,
    input  logic signed [47:0]                     i_raw_curvature,
    input  logic signed [47:0]                     i_raw_cos_angle,
    input  logic [46:0]                            i_surface_tension,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [47:0]                     o_net_force,
    output logic                                   o_evaluated,
    output logic                                   o_separated,
    input  logic                                   i_cfg_we,
    input  logic [fsfc_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [fsfc_pkg::WORD_BITS-1:0]         i_cfg_data
);

    localparam int W = fsfc_pkg::WORD_BITS;
    localparam int RCP_STEPS = W;   // quotient bits of 2^W / radius

    // Configuration registers
    logic [W-2:0]    r_gravity;
    fsfc_pkg::t_word r_threshold;
    fsfc_pkg::t_word r_min_ratio;
    fsfc_pkg::t_word r_min_curv;
    logic            r_radius_nz;

    // Serial reciprocal of the defined radius
    logic            r_busy;
    logic [5:0]      r_rcnt;
    logic [W-2:0]    r_rrem;
    logic [W-1:0]    r_recip;
    logic [W-2:0]    r_rden;
    logic [W-1:0]    n_rr2;
    logic            n_rge;
    logic [W-2:0]    n_rden;

    logic            adv;
    logic            in_acc;
    logic [9:0]      r_vld;

    // Stage 1
    fsfc_pkg::t_word n_k0, n_k1, n_c0, n_c1;
    fsfc_pkg::t_word r_s1_k, r_s1_c;
    fsfc_pkg::t_mag  r_s1_h, r_s1_rho, r_s1_u2, r_s1_sig;
    // Stages 2-3
    fsfc_pkg::t_pp   r_s2_pq, r_s2_phr, r_s2_prg, r_s2_psk;
    fsfc_pkg::t_word r_s2_k, r_s2_c;
    fsfc_pkg::t_mag  r_s2_h, r_s2_u2;
    fsfc_pkg::t_word r_s3_q, r_s3_hr, r_s3_rg, r_s3_sk, r_s3_k, r_s3_c;
    fsfc_pkg::t_mag  r_s3_h, r_s3_u2;
    // Stage 4
    fsfc_pkg::t_mag  n_qh;
    fsfc_pkg::t_word n_t;
    fsfc_pkg::t_word r_s4_s, r_s4_den, r_s4_hr, r_s4_rg, r_s4_sk, r_s4_k, r_s4_c;
    fsfc_pkg::t_mag  r_s4_h, r_s4_u2;
    logic            r_s4_eval;
    // Stages 5-6
    fsfc_pkg::t_pp   r_s5_pp2, r_s5_pfbc, r_s5_phs;
    fsfc_pkg::t_word r_s5_k, r_s5_sk, r_s5_den;
    logic            r_s5_eval;
    fsfc_pkg::t_word r_s6_p2, r_s6_fbc, r_s6_hs, r_s6_k, r_s6_sk, r_s6_den;
    logic            r_s6_eval;
    // Stages 7-8
    fsfc_pkg::t_pp   r_s7_pp3, r_s7_pfb;
    fsfc_pkg::t_word r_s7_sk, r_s7_den;
    logic            r_s7_eval;
    fsfc_pkg::t_word r_s8_p3, r_s8_fb, r_s8_sk, r_s8_den;
    logic            r_s8_eval;
    // Stages 9-10
    fsfc_pkg::t_pp   r_s9_pfi;
    fsfc_pkg::t_word r_s9_fb, r_s9_sk, r_s9_den;
    logic            r_s9_eval;
    fsfc_pkg::t_word r_s10_fi, r_s10_fb, r_s10_sk, r_s10_den;
    logic            r_s10_eval;
    // Divider and tail
    fsfc_pkg::t_div_req div_req;
    fsfc_pkg::t_div_rsp div_rsp;
    logic               div_vld;
    fsfc_pkg::t_word    r_f1_net;
    logic               r_f1_eval;
    logic               r_f1_vld;
    logic [W:0]         n_thr_sum;

    // Advance unless a finished result is held by the receiver
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv || r_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Reciprocal step: bring down the single leading numerator bit first
    always_comb begin
        n_rr2  = {r_rrem, (r_rcnt == 6'(RCP_STEPS))};
        n_rge  = n_rr2 >= {1'b0, r_rden};
        n_rden = (i_cfg_data[W-2:0] > fsfc_pkg::EPS_Q[W-2:0]) ?
                 i_cfg_data[W-2:0] : fsfc_pkg::EPS_Q[W-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= (W-1)'(164528285);
            r_threshold <= '0;
            r_min_ratio <= '0;
            r_min_curv  <= fsfc_pkg::t_word'(83886080);
            r_radius_nz <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fsfc_pkg::CFG_GRAVITY:   r_gravity   <= i_cfg_data[W-2:0];
                    fsfc_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    fsfc_pkg::CFG_RADIUS: begin
                        r_radius_nz <= (i_cfg_data[W-2:0] != '0);
                        r_busy      <= 1'b1;
                    end
                    fsfc_pkg::CFG_MIN_RATIO: r_min_ratio <= i_cfg_data;
                    fsfc_pkg::CFG_MIN_CURV:  r_min_curv  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_busy && !(i_cfg_we && i_cfg_index == fsfc_pkg::CFG_RADIUS) &&
                r_rcnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we && i_cfg_index == fsfc_pkg::CFG_RADIUS) begin
            r_rcnt  <= 6'(RCP_STEPS);
            r_rrem  <= '0;
            r_recip <= '0;
            r_rden  <= n_rden;
        end else if (r_busy) begin
            r_rcnt  <= r_rcnt - 6'd1;
            r_rrem  <= n_rge ? (W-1)'(n_rr2 - {1'b0, r_rden}) : n_rr2[W-2:0];
            r_recip <= {r_recip[W-2:0], n_rge};
        end
    end

    // Filter curvature, gate and clamp the cosine
    always_comb begin
        n_k0 = r_radius_nz ? fsfc_pkg::t_word'(r_recip) : i_raw_curvature;
        n_k1 = (fsfc_pkg::mag_of(n_k0) < fsfc_pkg::EPS_Q) ? fsfc_pkg::NEG_ONE_Q : n_k0;
        n_c0 = n_k1[W-1] ? '0 : i_raw_cos_angle;
        if (n_c0 > fsfc_pkg::ONE_Q) begin
            n_c1 = fsfc_pkg::ONE_Q;
        end else if (n_c0 < fsfc_pkg::NEG_ONE_Q) begin
            n_c1 = fsfc_pkg::NEG_ONE_Q;
        end else begin
            n_c1 = n_c0;
        end
    end

    // q*HALF is |q|/2 truncated toward zero
    always_comb begin
        n_qh = fsfc_pkg::mag_of(r_s3_q) >> 1;
        n_t  = r_s3_q[W-1] ? fsfc_pkg::t_word'(-n_qh) : fsfc_pkg::t_word'(n_qh);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_k   <= n_k1;
            r_s1_c   <= n_c1;
            r_s1_h   <= {1'b0, i_film_thickness};
            r_s1_rho <= {1'b0, i_density};
            r_s1_u2  <= {1'b0, i_speed_squared};
            r_s1_sig <= {1'b0, i_surface_tension};

            // q = h*k, h*rho, rho*g, sigma*k
            r_s2_pq  <= fsfc_pkg::mul_pp(r_s1_h, fsfc_pkg::mag_of(r_s1_k), r_s1_k[W-1]);
            r_s2_phr <= fsfc_pkg::mul_pp(r_s1_h, r_s1_rho, 1'b0);
            r_s2_prg <= fsfc_pkg::mul_pp(r_s1_rho, {1'b0, r_gravity}, 1'b0);
            r_s2_psk <= fsfc_pkg::mul_pp(r_s1_sig, fsfc_pkg::mag_of(r_s1_k), r_s1_k[W-1]);
            r_s2_k   <= r_s1_k;
            r_s2_c   <= r_s1_c;
            r_s2_h   <= r_s1_h;
            r_s2_u2  <= r_s1_u2;

            r_s3_q   <= fsfc_pkg::mul_fin(r_s2_pq);
            r_s3_hr  <= fsfc_pkg::mul_fin(r_s2_phr);
            r_s3_rg  <= fsfc_pkg::mul_fin(r_s2_prg);
            r_s3_sk  <= fsfc_pkg::mul_fin(r_s2_psk);
            r_s3_k   <= r_s2_k;
            r_s3_c   <= r_s2_c;
            r_s3_h   <= r_s2_h;
            r_s3_u2  <= r_s2_u2;

            r_s4_s    <= fsfc_pkg::sat_add(fsfc_pkg::ONE_Q, n_t);
            r_s4_den  <= fsfc_pkg::sat_add(fsfc_pkg::ONE_Q, r_s3_q);
            r_s4_eval <= (r_s3_k > r_min_curv) && (r_s3_q > r_min_ratio);
            r_s4_hr   <= r_s3_hr;
            r_s4_rg   <= r_s3_rg;
            r_s4_sk   <= r_s3_sk;
            r_s4_k    <= r_s3_k;
            r_s4_c    <= r_s3_c;
            r_s4_h    <= r_s3_h;
            r_s4_u2   <= r_s3_u2;

            // (h*rho)*U2, (rho*g)*c, h*(1 + q/2)
            r_s5_pp2  <= fsfc_pkg::mul_pp(fsfc_pkg::mag_of(r_s4_hr), r_s4_u2, r_s4_hr[W-1]);
            r_s5_pfbc <= fsfc_pkg::mul_pp(fsfc_pkg::mag_of(r_s4_rg), fsfc_pkg::mag_of(r_s4_c),
                                          r_s4_rg[W-1] ^ r_s4_c[W-1]);
            r_s5_phs  <= fsfc_pkg::mul_pp(r_s4_h, fsfc_pkg::mag_of(r_s4_s), r_s4_s[W-1]);
            r_s5_k    <= r_s4_k;
            r_s5_sk   <= r_s4_sk;
            r_s5_den  <= r_s4_den;
            r_s5_eval <= r_s4_eval;

            r_s6_p2   <= fsfc_pkg::mul_fin(r_s5_pp2);
            r_s6_fbc  <= fsfc_pkg::mul_fin(r_s5_pfbc);
            r_s6_hs   <= fsfc_pkg::mul_fin(r_s5_phs);
            r_s6_k    <= r_s5_k;
            r_s6_sk   <= r_s5_sk;
            r_s6_den  <= r_s5_den;
            r_s6_eval <= r_s5_eval;

            r_s7_pp3  <= fsfc_pkg::mul_pp(fsfc_pkg::mag_of(r_s6_p2), fsfc_pkg::mag_of(r_s6_k),
                                          r_s6_p2[W-1] ^ r_s6_k[W-1]);
            r_s7_pfb  <= fsfc_pkg::mul_pp(fsfc_pkg::mag_of(r_s6_fbc), fsfc_pkg::mag_of(r_s6_hs),
                                          r_s6_fbc[W-1] ^ r_s6_hs[W-1]);
            r_s7_sk   <= r_s6_sk;
            r_s7_den  <= r_s6_den;
            r_s7_eval <= r_s6_eval;

            r_s8_p3   <= fsfc_pkg::mul_fin(r_s7_pp3);
            r_s8_fb   <= fsfc_pkg::mul_fin(r_s7_pfb);
            r_s8_sk   <= r_s7_sk;
            r_s8_den  <= r_s7_den;
            r_s8_eval <= r_s7_eval;

            // Inertial term carries the negative 4/3 factor
            r_s9_pfi  <= fsfc_pkg::mul_pp(fsfc_pkg::K43_Q, fsfc_pkg::mag_of(r_s8_p3),
                                          !r_s8_p3[W-1]);
            r_s9_fb   <= r_s8_fb;
            r_s9_sk   <= r_s8_sk;
            r_s9_den  <= r_s8_den;
            r_s9_eval <= r_s8_eval;

            r_s10_fi   <= fsfc_pkg::mul_fin(r_s9_pfi);
            r_s10_fb   <= r_s9_fb;
            r_s10_sk   <= r_s9_sk;
            r_s10_den  <= r_s9_den;
            r_s10_eval <= r_s9_eval;

            // Zero the force when the minimums fail
            r_f1_net  <= div_rsp.eval ? fsfc_pkg::sat_add(div_rsp.side, div_rsp.quo) : '0;
            r_f1_eval <= div_rsp.eval;

            o_net_force <= r_f1_net;
            o_evaluated <= r_f1_eval;
            o_separated <= n_thr_sum[W];
        end
    end

    // Sign of net + threshold is exact in one extra bit
    assign n_thr_sum = {r_f1_net[W-1], r_f1_net} + {r_threshold[W-1], r_threshold};

    always_comb begin
        div_req.num  = r_s10_sk;
        div_req.den  = r_s10_den;
        div_req.side = fsfc_pkg::sat_add(r_s10_fi, r_s10_fb);
        div_req.eval = r_s10_eval;
    end

    // Surface term sigma*k / (1 + h*k)
    fsfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_vld[9]),
        .i_req   (div_req),
        .o_valid (div_vld),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_f1_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[8:0], in_acc};
            r_f1_vld    <= div_vld;
            o_out_valid <= r_f1_vld;
        end
    end

endmodule

/* sv/fsfc_checker.sv */
`include "film_separation_force_check_core_assert.svh"

module fsfc_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic [46:0]                            i_film_thickness,
    input logic [46:0]                            i_density,
    input logic [46:0]                            i_speed_squared,
    input logic signed [47:0]                     i_raw_curvature,
    input logic signed [47:0]                     i_raw_cos_angle,
    input logic [46:0]                            i_surface_tension,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [47:0]                     o_net_force,
    input logic                                   o_evaluated,
    input logic                                   o_separated,
    input logic                                   i_cfg_we,
    input logic [fsfc_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input logic [fsfc_pkg::WORD_BITS-1:0]         i_cfg_data
);

    // Skipped faces report zero force
    `FSFC_ASSERT(a_zero_when_skipped, i_clk, i_rst_n, (o_out_valid && !o_evaluated) |-> (o_net_force == '0))

    // A radius write starts the reciprocal unit, which blocks input
    `FSFC_ASSERT(a_radius_blocks, i_clk, i_rst_n, (i_cfg_we && i_cfg_index == fsfc_pkg::CFG_RADIUS) |=> o_in_stall)

    // A held result keeps its beat
    `FSFC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_net_force) && $stable(o_separated)))

    // Reset empties the output
    `FSFC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind film_separation_force_check_core fsfc_checker u_fsfc_checker (.*);

/* tb/sv/film_separation_force_check_core_tb.sv */
`timescale 1ns / 100ps

module film_separation_force_check_core_tb;

    localparam int     CYCLE_LIMIT = 600000;
    localparam int     DRAIN_CYCLES = 80;   // pipeline depth plus margin
    localparam longint Q_ONE = longint'(1) << fsfc_pkg::FRAC_BITS;
    localparam longint Q_HALF = longint'(1) << (fsfc_pkg::FRAC_BITS - 1);
    localparam longint Q_EPS = ((longint'(1) << fsfc_pkg::FRAC_BITS) + 500000) / 1000000;
    localparam longint Q_K43 = ((longint'(4) << fsfc_pkg::FRAC_BITS) + 1) / 3;
    localparam longint W_MAX = (longint'(1) << (fsfc_pkg::WORD_BITS - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;
    localparam longint U_MAX = W_MAX;       // largest 47-bit unsigned field
    localparam logic [fsfc_pkg::CFG_IDX_BITS-1:0] CFG_UNKNOWN = 3'd7;

    typedef enum logic {ROW_FACE, ROW_REG} t_row_kind;

    typedef struct {
        logic [46:0]        thick;
        logic [46:0]        dens;
        logic [46:0]        u2;
        logic signed [47:0] curv;
        logic signed [47:0] cosang;
        logic [46:0]        sigma;
    } t_face;

    typedef struct {
        logic signed [47:0] force_q;
        logic               eval;
        logic               sep;
    } t_verdict;

    typedef struct {
        t_row_kind                         kind;
        t_face                             face;
        logic [fsfc_pkg::CFG_IDX_BITS-1:0] reg_idx;
        logic [fsfc_pkg::WORD_BITS-1:0]    reg_val;
        bit                                typed;     // verdict below is typed in
        t_verdict                          verdict;
    } t_row;

    logic                                 i_clk;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic [46:0]                          i_film_thickness = '0;
    logic [46:0]                          i_density = '0;
    logic [46:0]                          i_speed_squared = '0;
    logic signed [47:0]                   i_raw_curvature = '0;
    logic signed [47:0]                   i_raw_cos_angle = '0;
    logic [46:0]                          i_surface_tension = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic signed [47:0]                   o_net_force;
    logic                                 o_evaluated;
    logic                                 o_separated;
    logic                                 i_cfg_we = 1'b0;
    logic [fsfc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index = '0;
    logic [fsfc_pkg::WORD_BITS-1:0]       i_cfg_data = '0;

    film_separation_force_check_core uut (.*);

    // Register shadow, updated on every write we issue
    longint   gravity_q, threshold_q, radius_q, min_ratio_q, min_curv_q;
    t_verdict verdicts_due[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       idle_pct = 0;     // chance per cycle that the sender holds off
    int       stall_pct = 0;    // chance per cycle that the receiver stalls
    t_row     dir_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Fixed-point helpers: products and quotients on magnitudes, then clip
    // ---------------------------------------------------------------------
    function automatic longint clip_mag(bit neg, logic [127:0] m);
        logic [127:0] lim;
        lim = neg ? 128'(W_MAX + 1) : 128'(W_MAX);
        if (m > lim) m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [63:0] abs_q(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [127:0] p;
        p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
        return clip_mag((a < 0) != (b < 0), p >> fsfc_pkg::FRAC_BITS);
    endfunction

    function automatic longint q_div(longint a, longint b);
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        if (a == 0) return 0;
        if (b == 0) return neg ? W_MIN : W_MAX;
        p = ({64'd0, abs_q(a)} << fsfc_pkg::FRAC_BITS) / {64'd0, abs_q(b)};
        return clip_mag(neg, p);
    endfunction

    function automatic longint q_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > W_MAX) return W_MAX;
        if (s < W_MIN) return W_MIN;
        return s;
    endfunction

    // Force balance on one face: inertial + body + surface tension terms
    function automatic t_verdict face_verdict(t_face f);
        t_verdict v;
        longint   h, rho, u2, k, c, sig, q, fi, fb, fs, net;
        h   = longint'(f.thick);
        rho = longint'(f.dens);
        u2  = longint'(f.u2);
        sig = longint'(f.sigma);
        k   = longint'(f.curv);
        c   = longint'(f.cosang);
        net = 0;
        // A fixed radius overrides the measured curvature
        if (radius_q != 0) k = q_div(Q_ONE, radius_q > Q_EPS ? radius_q : Q_EPS);
        // Flat faces count as concave
        if (abs_q(k) < 64'(Q_EPS)) k = -Q_ONE;
        if (k < 0) c = 0;
        if (c > Q_ONE) c = Q_ONE;
        if (c < -Q_ONE) c = -Q_ONE;
        q = q_mul(h, k);
        v.eval = (k > min_curv_q) && (q > min_ratio_q);
        if (v.eval) begin
            fi  = q_mul(-Q_K43, q_mul(q_mul(q_mul(h, rho), u2), k));
            fb  = q_mul(q_mul(q_mul(rho, gravity_q), c),
                        q_mul(h, q_add(Q_ONE, q_mul(q, Q_HALF))));
            fs  = q_div(q_mul(sig, k), q_add(Q_ONE, q));
            net = q_add(q_add(fi, fb), fs);
        end
        v.force_q = 48'(net);
        v.sep     = q_add(net, threshold_q) < 0;
        return v;
    endfunction

    // ---------------------------------------------------------------------
    // Mismatch reporting
    // ---------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Receiver: stall at random, driven on the falling edge
    always @(negedge i_clk) i_out_stall <= ($urandom_range(99) < stall_pct);

    // Result monitor: compare each output beat with the oldest verdict due
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("result beat with no verdict pending", 1, 0);
            end else begin
                want = verdicts_due.pop_front();
                if (o_net_force !== want.force_q)
                    report_mismatch("net_force", longint'(o_net_force),
                                    longint'(want.force_q));
                if (o_evaluated !== want.eval)
                    report_mismatch("evaluated", longint'(o_evaluated), longint'(want.eval));
                if (o_separated !== want.sep)
                    report_mismatch("separated", longint'(o_separated), longint'(want.sep));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus tasks; each is entered and left on a falling edge
    // ---------------------------------------------------------------------

    // Send one face beat; queue its verdict on acceptance
    task automatic send_face(t_face f, bit typed, t_verdict typed_v);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_film_thickness  <= f.thick;
        i_density         <= f.dens;
        i_speed_squared   <= f.u2;
        i_raw_curvature   <= f.curv;
        i_raw_cos_angle   <= f.cosang;
        i_surface_tension <= f.sigma;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
        end
        verdicts_due.push_back(typed ? typed_v : face_verdict(f));
        @(negedge i_clk);
    endtask

    // Hold off until every pending verdict has been matched
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register write; caller has drained the pipe first
    task automatic write_reg(logic [fsfc_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [fsfc_pkg::WORD_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            fsfc_pkg::CFG_GRAVITY:   gravity_q   = longint'(val[46:0]);
            fsfc_pkg::CFG_THRESHOLD: threshold_q = longint'($signed(val));
            fsfc_pkg::CFG_RADIUS:    radius_q    = longint'(val[46:0]);
            fsfc_pkg::CFG_MIN_RATIO: min_ratio_q = longint'($signed(val));
            fsfc_pkg::CFG_MIN_CURV:  min_curv_q  = longint'($signed(val));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // Unsigned field: mostly plausible physical values, some extremes
    function automatic logic [46:0] rand_unsigned();
        case ($urandom_range(9))
            0, 1: return 47'(rand48());
            2:    return 47'(U_MAX);
            3:    return '0;
            4:    return 47'($urandom_range(255));
            default: return 47'({$urandom_range(3), $urandom});
        endcase
    endfunction

    // Curvature: mostly above the default minimum so the force terms run
    function automatic logic signed [47:0] rand_curv();
        case ($urandom_range(9))
            0:    return rand48();
            1:    return -48'($urandom);
            2:    return 48'($urandom_range(40)) - 48'sd20;   // around zero
            3:    return $urandom_range(1) ? 48'(W_MAX) : 48'(W_MIN);
            default: return 48'({$urandom_range(63), $urandom});
        endcase
    endfunction

    // Gravity cosine: mostly inside [-1, 1], some far outside
    function automatic logic signed [47:0] rand_cos();
        case ($urandom_range(7))
            0:    return rand48();
            1:    return $urandom_range(1) ? 48'(Q_ONE) : -48'(Q_ONE);
            default: return 48'($urandom_range(32'(2 * Q_ONE))) - 48'(Q_ONE);
        endcase
    endfunction

    function automatic t_face rand_face();
        t_face f;
        f.thick  = rand_unsigned();
        f.dens   = rand_unsigned();
        f.u2     = rand_unsigned();
        f.curv   = rand_curv();
        f.cosang = rand_cos();
        f.sigma  = rand_unsigned();
        return f;
    endfunction

    function automatic t_row face_row(logic [46:0] h, logic [46:0] rho, logic [46:0] u2,
                                      logic signed [47:0] k, logic signed [47:0] c,
                                      logic [46:0] sig);
        t_row r;
        r.kind    = ROW_FACE;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.typed   = 1'b0;
        r.verdict = '{'0, 1'b0, 1'b0};
        r.face    = '{h, rho, u2, k, c, sig};
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, logic signed [47:0] f, logic e, logic s);
        r.typed   = 1'b1;
        r.verdict = '{f, e, s};
        return r;
    endfunction

    function automatic t_row reg_row(logic [fsfc_pkg::CFG_IDX_BITS-1:0] idx,
                                     logic [fsfc_pkg::WORD_BITS-1:0] v);
        t_row r;
        r.kind    = ROW_REG;
        r.face    = '{'0, '0, '0, '0, '0, '0};
        r.typed   = 1'b0;
        r.verdict = '{'0, 1'b0, 1'b0};
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        t_face f;
        int    n;
        gravity_q   = 164528285;
        threshold_q = 0;
        radius_q    = 0;
        min_ratio_q = 0;
        min_curv_q  = 83886080;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table. Typed verdicts hold for reset registers: a flat or
        // concave face is never evaluated, and with a zero threshold it
        // cannot be flagged either.
        dir_rows.push_back(typed_row(face_row('0, '0, '0, '0, '0, '0), '0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(face_row(47'(U_MAX), 47'(U_MAX), 47'(U_MAX),
                                              48'(W_MIN), 48'(W_MAX), 47'(U_MAX)),
                                     '0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(face_row(47'(Q_ONE), 47'(Q_ONE), 47'(Q_ONE),
                                              48'sd16, 48'(Q_ONE), 47'(Q_ONE)),
                                     '0, 1'b0, 1'b0));
        dir_rows.push_back(face_row(47'(U_MAX), 47'(U_MAX), 47'(U_MAX), 48'(W_MAX),
                                    48'(W_MAX), 47'(U_MAX)));
        dir_rows.push_back(face_row(47'(Q_ONE / 1000), 47'(1000 * Q_ONE), 47'(Q_ONE),
                                    48'(10 * Q_ONE), 48'(Q_ONE / 2), 47'(Q_ONE / 10)));
        dir_rows.push_back(face_row(47'(Q_ONE / 100), 47'(Q_ONE), 47'(4 * Q_ONE),
                                    48'(8 * Q_ONE), 48'(3 * Q_ONE), 47'(Q_ONE)));
        dir_rows.push_back(face_row(47'(Q_ONE / 100), 47'(Q_ONE), 47'(4 * Q_ONE),
                                    48'(8 * Q_ONE), -48'(3 * Q_ONE), 47'(Q_ONE)));
        // Negative threshold: an unevaluated face is always flagged
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_THRESHOLD, -48'(Q_ONE)));
        dir_rows.push_back(typed_row(face_row('0, '0, '0, '0, '0, '0), '0, 1'b0, 1'b1));
        // Open both minimums so h*k = -1 reaches the surface-term divider
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_MIN_CURV, 48'(W_MIN)));
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_MIN_RATIO, 48'(W_MIN)));
        dir_rows.push_back(face_row(47'(Q_ONE), 47'(Q_ONE), 47'(Q_ONE),
                                    -48'(Q_ONE), 48'(Q_ONE), 47'(Q_ONE)));
        dir_rows.push_back(face_row(47'(Q_ONE), 47'(Q_ONE), 47'(Q_ONE),
                                    -48'(Q_ONE), 48'(Q_ONE), '0));
        // Fixed radius below the floor, then an ordinary one, then off
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_RADIUS, 48'd1));
        dir_rows.push_back(face_row(47'(Q_ONE), 47'(Q_ONE), 47'(Q_ONE), '0,
                                    48'(Q_ONE / 2), 47'(Q_ONE)));
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_RADIUS, 48'(2 * Q_ONE) | (48'd1 << 47)));
        dir_rows.push_back(face_row(47'(Q_ONE / 10), 47'(Q_ONE), 47'(Q_ONE), 48'(W_MIN),
                                    48'(Q_ONE / 2), 47'(Q_ONE)));
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_RADIUS, 48'd0));
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_GRAVITY, 48'(U_MAX)));
        dir_rows.push_back(reg_row(fsfc_pkg::CFG_THRESHOLD, 48'(W_MAX)));
        dir_rows.push_back(reg_row(CFG_UNKNOWN, 48'(W_MAX)));   // dropped
        dir_rows.push_back(face_row(47'(U_MAX), 47'(Q_ONE), 47'(Q_ONE), 48'(Q_ONE),
                                    48'(Q_ONE), 47'(U_MAX)));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                drain_results();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_face(dir_rows[i].face, dir_rows[i].typed, dir_rows[i].verdict);
            end
        end

        // Random phases, one idling mode each: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            idle_pct  = (ph == 1) ? 88 : (ph == 3) ? 25 : 0;
            stall_pct = (ph == 2) ? 88 : (ph == 3) ? 25 : 0;
            // Fresh register setting; phase 0 restores reset values
            write_reg(fsfc_pkg::CFG_GRAVITY,
                      ph == 0 ? 48'd164528285 : 48'($urandom_range(1 << 30)));
            write_reg(fsfc_pkg::CFG_THRESHOLD, ph == 0 ? 48'd0 : rand48());
            write_reg(fsfc_pkg::CFG_RADIUS,
                      ph == 2 ? 48'($urandom_range(32'(3 * Q_ONE))) : 48'd0);
            write_reg(fsfc_pkg::CFG_MIN_RATIO,
                      ph == 3 ? 48'(W_MIN) : ph == 0 ? 48'd0 : -48'($urandom));
            write_reg(fsfc_pkg::CFG_MIN_CURV,
                      ph == 3 ? 48'(W_MAX) : ph == 0 ? 48'd83886080
                              : 48'($urandom_range(32'(8 * Q_ONE))));
            if (ph == 3) write_reg(fsfc_pkg::CFG_MIN_CURV, 48'(W_MIN));
            n = 200;
            for (int j = 0; j < n; j++) begin
                if (j == n / 2) drain_results();   // let the pipe run dry once
                f = rand_face();
                send_face(f, 1'b0, '{default: '0});
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
